// File: src/qrv_pkg.sv
// qrv_pkg: constants shared by the quaternion vector rotation pipeline
// no dependencies; used by quaternion_rotate_vector_unit and its testbench
`timescale 1ns / 1ps
`default_nettype none

package qrv_pkg;

    // guard bits of the first-product intermediate over the data width
    localparam int MID_EXTRA = 4;
    // arithmetic wraps at this many bits
    localparam int WRAP_W = 64;
    // number of register stages
    localparam int N_STAGES = 5;
    // partial products per Hamilton product
    localparam int N_PROD = 12;
    // quaternion and vector component counts
    localparam int N_QUAT = 4;
    localparam int N_VEC = 3;

endpackage

`default_nettype wire

// File: src/quaternion_rotate_vector_unit.sv
// quaternion_rotate_vector_unit: rotates a vector by a quaternion, q * (0,v) * conj(q)
// depends on qrv_pkg for shared constants
//
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata: quat_w,x,y,z, vec_x,y,z
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: rot_x,y,z; tuser: saturated
//
// one word per cycle sustained while the output accepts, five register stages; a word accepted
// passes through each stage register in order and can leave from the output register
// stages: input reg, first products, round/clip, second products, round/saturate
// each stage holds its own valid bit; a stage loads when it is empty or its
// successor moves, so bubbles are squeezed out and a stall loses nothing
// synchronous active-low reset clears the valid bits only
`timescale 1ns / 1ps
`default_nettype none

module quaternion_rotate_vector_unit #(
    parameter int FRAC_BITS  = 14,
    parameter int DATA_WIDTH = 16,
    localparam int IN_W  = ((7 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, zero pad
    input  wire logic [IN_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    // rot_x, rot_y, rot_z, zero pad
    output logic [OUT_W-1:0]      o_m_axis_tdata,
    // saturated
    output logic [0:0]            o_m_axis_tuser
);

    localparam int DW    = DATA_WIDTH;
    localparam int NS    = qrv_pkg::N_STAGES;
    localparam int NP    = qrv_pkg::N_PROD;
    localparam int NQ    = qrv_pkg::N_QUAT;
    localparam int NV    = qrv_pkg::N_VEC;
    localparam int MID_W = DW + qrv_pkg::MID_EXTRA;

    // first product: sums of three products plus rounding
    localparam int P1_W  = 2 * DW;
    localparam int R1_W  = (2 * DW + 3 > qrv_pkg::WRAP_W) ? qrv_pkg::WRAP_W : 2 * DW + 3;
    localparam int X1_W  = (R1_W > FRAC_BITS) ? R1_W : FRAC_BITS + 1;
    localparam int SH1_W = X1_W - FRAC_BITS;
    localparam int E1_W  = ((SH1_W > MID_W) ? SH1_W : MID_W) + 1;

    // second product: sums of four products plus rounding
    localparam int P2_W  = MID_W + DW;
    localparam int R2_W  = (3 * DW + 7 > qrv_pkg::WRAP_W) ? qrv_pkg::WRAP_W : 3 * DW + 7;
    localparam int PX2_W = (P2_W > R2_W) ? P2_W : R2_W;
    localparam int X2_W  = (R2_W > FRAC_BITS) ? R2_W : FRAC_BITS + 1;
    localparam int SH2_W = X2_W - FRAC_BITS;
    localparam int E2_W  = ((SH2_W > DW) ? SH2_W : DW) + 1;

    localparam logic [X1_W-1:0] RND1 = X1_W'(1) << (FRAC_BITS - 1);
    localparam logic [X2_W-1:0] RND2 = X2_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [E1_W-1:0] HI1 = E1_W'((longint'(1) <<< (MID_W - 1)) - 1);
    localparam logic signed [E1_W-1:0] LO1 = ~HI1;
    localparam logic signed [E2_W-1:0] HI2 = E2_W'((longint'(1) <<< (DW - 1)) - 1);
    localparam logic signed [E2_W-1:0] LO2 = ~HI2;
    localparam logic signed [DW-1:0] ROT_HI = HI2[DW-1:0];
    localparam logic signed [DW-1:0] ROT_LO = LO2[DW-1:0];

    // stage control
    logic [NS-1:0] r_valid;
    logic [NS-1:0] rdy;

    // stage payloads
    logic signed [DW-1:0]    r_q0 [NQ];
    logic signed [DW-1:0]    r_v0 [NV];
    logic signed [DW-1:0]    r_q1 [NQ];
    logic signed [P1_W-1:0]  r_m1 [NP];
    logic signed [DW-1:0]    r_q2 [NQ];
    logic signed [MID_W-1:0] r_p2 [NQ];
    logic signed [P2_W-1:0]  r_m3 [NP];
    logic signed [DW-1:0]    r_rot [NV];
    logic                    r_sat;

    // next values
    logic signed [P1_W-1:0]  n_m1 [NP];
    logic signed [MID_W-1:0] n_p2 [NQ];
    logic signed [P2_W-1:0]  n_m3 [NP];
    logic signed [DW-1:0]    n_rot [NV];
    logic                    n_sat;

    // combinational helpers
    logic signed [R1_W-1:0]  e1 [NP];
    logic signed [R1_W-1:0]  sum1 [NQ];
    logic [X1_W-1:0]         rnd1 [NQ];
    logic signed [E1_W-1:0]  t1 [NQ];
    logic signed [E1_W-1:0]  c1 [NQ];
    logic signed [PX2_W-1:0] x3 [NP];
    logic signed [R2_W-1:0]  e3 [NP];
    logic signed [R2_W-1:0]  sum3 [NV];
    logic [X2_W-1:0]         rnd3 [NV];
    logic signed [E2_W-1:0]  t3 [NV];
    logic signed [E2_W-1:0]  c3 [NV];

    always_comb begin
        rdy[NS-1] = !r_valid[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
    end

    assign o_s_axis_tready = rdy[0];

    // first Hamilton product terms, q[i] * v[j]
    always_comb begin
        for (int i = 0; i < NQ; i++) begin
            for (int j = 0; j < NV; j++) begin
                n_m1[NV*i+j] = r_q0[i] * r_v0[j];
            end
        end
    end

    // p = q * (0,v), round half-up, clip to intermediate width
    always_comb begin
        for (int k = 0; k < NP; k++) begin
            e1[k] = R1_W'(r_m1[k]);
        end
        sum1[0] = -e1[3] - e1[7] - e1[11];
        sum1[1] = e1[0] + e1[8] - e1[10];
        sum1[2] = e1[1] - e1[5] + e1[9];
        sum1[3] = e1[2] + e1[4] - e1[6];
        for (int i = 0; i < NQ; i++) begin
            rnd1[i] = X1_W'(sum1[i]) + RND1;
            t1[i]   = E1_W'($signed(rnd1[i][X1_W-1:FRAC_BITS]));
            if (t1[i] > HI1) begin
                c1[i] = HI1;
            end else if (t1[i] < LO1) begin
                c1[i] = LO1;
            end else begin
                c1[i] = t1[i];
            end
            n_p2[i] = c1[i][MID_W-1:0];
        end
    end

    // second Hamilton product terms, order rx, ry, rz
    always_comb begin
        n_m3[0]  = r_p2[1] * r_q2[0];
        n_m3[1]  = r_p2[0] * r_q2[1];
        n_m3[2]  = r_p2[2] * r_q2[3];
        n_m3[3]  = r_p2[3] * r_q2[2];
        n_m3[4]  = r_p2[2] * r_q2[0];
        n_m3[5]  = r_p2[0] * r_q2[2];
        n_m3[6]  = r_p2[1] * r_q2[3];
        n_m3[7]  = r_p2[3] * r_q2[1];
        n_m3[8]  = r_p2[3] * r_q2[0];
        n_m3[9]  = r_p2[0] * r_q2[3];
        n_m3[10] = r_p2[1] * r_q2[2];
        n_m3[11] = r_p2[2] * r_q2[1];
    end

    // r = p * conj(q), round half-up, saturate
    always_comb begin
        for (int k = 0; k < NP; k++) begin
            x3[k] = PX2_W'(r_m3[k]);
            e3[k] = $signed(x3[k][R2_W-1:0]);
        end
        sum3[0] = e3[0] - e3[1] - e3[2] + e3[3];
        sum3[1] = e3[4] - e3[5] + e3[6] - e3[7];
        sum3[2] = e3[8] - e3[9] - e3[10] + e3[11];
        n_sat = 1'b0;
        for (int i = 0; i < NV; i++) begin
            rnd3[i] = X2_W'(sum3[i]) + RND2;
            t3[i]   = E2_W'($signed(rnd3[i][X2_W-1:FRAC_BITS]));
            if (t3[i] > HI2) begin
                c3[i] = HI2;
                n_sat = 1'b1;
            end else if (t3[i] < LO2) begin
                c3[i] = LO2;
                n_sat = 1'b1;
            end else begin
                c3[i] = t3[i];
            end
            n_rot[i] = c3[i][DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (rdy[0]) begin
                r_valid[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && rdy[0]) begin
            for (int i = 0; i < NQ; i++) begin
                r_q0[i] <= i_s_axis_tdata[DW*i +: DW];
            end
            for (int j = 0; j < NV; j++) begin
                r_v0[j] <= i_s_axis_tdata[DW*(NQ+j) +: DW];
            end
        end
        if (r_valid[0] && rdy[1]) begin
            r_q1 <= r_q0;
            r_m1 <= n_m1;
        end
        if (r_valid[1] && rdy[2]) begin
            r_q2 <= r_q1;
            r_p2 <= n_p2;
        end
        if (r_valid[2] && rdy[3]) begin
            r_m3 <= n_m3;
        end
        if (r_valid[3] && rdy[4]) begin
            r_rot <= n_rot;
            r_sat <= n_sat;
        end
    end

    assign o_m_axis_tvalid   = r_valid[NS-1];
    assign o_m_axis_tdata    = OUT_W'({r_rot[2], r_rot[1], r_rot[0]});
    assign o_m_axis_tuser[0] = r_sat;

    // input only stalls when every stage holds a word
    a_full_before_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_valid))
        else $error("input stalled with an empty stage");

    // reset empties the output stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // saturation flag implies a component sits at a range limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
        (r_rot[0] == ROT_HI || r_rot[0] == ROT_LO ||
         r_rot[1] == ROT_HI || r_rot[1] == ROT_LO ||
         r_rot[2] == ROT_HI || r_rot[2] == ROT_LO))
        else $error("saturated flag without a clipped component");

endmodule

`default_nettype wire

// File: verif/tb_quaternion_rotate_vector_unit.sv
// testbench for quaternion_rotate_vector_unit: a table of directed words, then random words
// with bursty input and a stalling output, each checked against its table result or a behavioral rotation predictor
// depends on src/qrv_pkg.sv and src/quaternion_rotate_vector_unit.sv
`timescale 1ns / 1ps

module tb_quaternion_rotate_vector_unit;

    localparam int FRAC_BITS  = 14;
    localparam int DATA_WIDTH = 16;
    localparam int MID_W      = DATA_WIDTH + qrv_pkg::MID_EXTRA;
    localparam int IN_W       = ((7 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_W      = ((3 * DATA_WIDTH + 7) / 8) * 8;
    localparam int N_RANDOM   = 700;
    localparam int N_PRESSURE = 80;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;

    typedef logic signed [DATA_WIDTH-1:0] t_comp;

    typedef struct {
        t_comp qw, qx, qy, qz;
        t_comp vx, vy, vz;
    } t_rot_req;

    typedef struct {
        t_comp rx, ry, rz;
        logic  sat;
    } t_rot_res;

    typedef struct {
        t_rot_req req;
        bit       known;
        t_rot_res res;
    } t_rot_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
    logic [IN_W-1:0]  i_s_axis_tdata;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    // rot_x, rot_y, rot_z
    logic [OUT_W-1:0] o_m_axis_tdata;
    // saturated
    logic [0:0]       o_m_axis_tuser;

    t_rot_row stim_rows[$];
    t_rot_res rot_expected[$];
    int       n_directed;
    int       words_sent;
    int       results_seen;
    int       sat_seen;
    int       mismatches;
    bit       hold_req;

    quaternion_rotate_vector_unit #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // round half toward plus infinity, then drop the fraction bits
    function automatic longint round_frac(longint s);
        return (s + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp_to(longint v, int w, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // q * (0,v) * conj(q), vector part
    function automatic t_rot_res rotate_vector(t_rot_req q);
        longint w, qx, qy, qz, vx, vy, vz;
        longint pr, px, py, pz, rx, ry, rz;
        bit mid_hit;
        bit hit;
        t_rot_res r;
        w  = q.qw;  qx = q.qx;  qy = q.qy;  qz = q.qz;
        vx = q.vx;  vy = q.vy;  vz = q.vz;
        mid_hit = 1'b0;
        hit = 1'b0;
        pr = clamp_to(round_frac(-(qx * vx) - qy * vy - qz * vz), MID_W, mid_hit);
        px = clamp_to(round_frac(w * vx + qy * vz - qz * vy), MID_W, mid_hit);
        py = clamp_to(round_frac(w * vy - qx * vz + qz * vx), MID_W, mid_hit);
        pz = clamp_to(round_frac(w * vz + qx * vy - qy * vx), MID_W, mid_hit);
        rx = clamp_to(round_frac(px * w - pr * qx - py * qz + pz * qy), DATA_WIDTH, hit);
        ry = clamp_to(round_frac(py * w - pr * qy + px * qz - pz * qx), DATA_WIDTH, hit);
        rz = clamp_to(round_frac(pz * w - pr * qz - px * qy + py * qx), DATA_WIDTH, hit);
        r.rx  = rx[DATA_WIDTH-1:0];
        r.ry  = ry[DATA_WIDTH-1:0];
        r.rz  = rz[DATA_WIDTH-1:0];
        r.sat = hit;
        return r;
    endfunction

    task automatic add_row(input int qw, input int qx, input int qy, input int qz,
                           input int vx, input int vy, input int vz,
                           input bit known = 1'b0, input int ex = 0, input int ey = 0,
                           input int ez = 0, input bit es = 1'b0);
        t_rot_row row;
        row.req.qw = t_comp'(qw);
        row.req.qx = t_comp'(qx);
        row.req.qy = t_comp'(qy);
        row.req.qz = t_comp'(qz);
        row.req.vx = t_comp'(vx);
        row.req.vy = t_comp'(vy);
        row.req.vz = t_comp'(vz);
        row.known  = known;
        row.res.rx = t_comp'(ex);
        row.res.ry = t_comp'(ey);
        row.res.rz = t_comp'(ez);
        row.res.sat = es;
        stim_rows.push_back(row);
    endtask

    // 0 full range, 1 about unit scale, 2 small, 3 extremes
    function automatic t_comp pick_comp(int mode);
        case (mode)
            1: return t_comp'(int'($urandom_range(0, 32768)) - 16384);
            2: return t_comp'(int'($urandom_range(0, 2000)) - 1000);
            3: begin
                case ($urandom_range(0, 4))
                    0: return t_comp'(-32768);
                    1: return t_comp'(32767);
                    2: return t_comp'(0);
                    3: return t_comp'(-1);
                    default: return t_comp'(16384);
                endcase
            end
            default: return t_comp'($urandom);
        endcase
    endfunction

    function automatic t_rot_req random_req();
        t_rot_req q;
        int qm;
        int vm;
        qm = ($urandom_range(0, 9) < 5) ? 1 : 0;
        vm = $urandom_range(0, 9);
        vm = (vm < 6) ? 0 : ((vm < 9) ? 2 : 3);
        q.qw = ($urandom_range(0, 9) == 0) ? pick_comp(3) : pick_comp(qm);
        q.qx = ($urandom_range(0, 9) == 0) ? pick_comp(3) : pick_comp(qm);
        q.qy = ($urandom_range(0, 9) == 0) ? pick_comp(3) : pick_comp(qm);
        q.qz = ($urandom_range(0, 9) == 0) ? pick_comp(3) : pick_comp(qm);
        q.vx = pick_comp(vm);
        q.vy = pick_comp(vm);
        q.vz = pick_comp(vm);
        return q;
    endfunction

    // receiver: one of four randomly drawn stall patterns, with one long hold on request
    initial begin
        int cyc;
        int rx_mode;
        int period;
        i_m_axis_tready = 1'b0;
        cyc = 0;
        rx_mode = 0;
        period = 3;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (cyc % 64 == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    period = $urandom_range(2, 5);
                end
                case (rx_mode)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= ($urandom_range(0, 9) < 7);
                    2: i_m_axis_tready <= ((cyc % period) != 0);
                    default: i_m_axis_tready <= ($urandom_range(0, 9) < 3);
                endcase
                cyc++;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_rot_res want;
        t_comp gx, gy, gz;
        logic gs;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            gx = o_m_axis_tdata[DATA_WIDTH-1:0];
            gy = o_m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
            gz = o_m_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];
            gs = o_m_axis_tuser[0];
            results_seen++;
            if (gs === 1'b1)
                sat_seen++;
            if (rot_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word (%0d,%0d,%0d,%0b)", gx, gy, gz, gs);
            end else begin
                want = rot_expected.pop_front();
                if (gx !== want.rx || gy !== want.ry || gz !== want.rz || gs !== want.sat) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: expected (%0d,%0d,%0d,%0b) got (%0d,%0d,%0d,%0b)",
                                 results_seen, want.rx, want.ry, want.rz, want.sat,
                                 gx, gy, gz, gs);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int burst_left;
        int gap;
        t_rot_row row;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        hold_req = 1'b0;
        words_sent = 0;
        results_seen = 0;
        sat_seen = 0;
        mismatches = 0;

        // identity, zero, half scale rounding, half turns, scale by 4
        add_row(16384, 0, 0, 0, 1, 2, 3, 1'b1, 1, 2, 3, 1'b0);
        add_row(16384, 0, 0, 0, 32767, -32768, 0, 1'b1, 32767, -32768, 0, 1'b0);
        add_row(0, 0, 0, 0, 32767, -32768, -1, 1'b1, 0, 0, 0, 1'b0);
        add_row(8192, 0, 0, 0, 1, -1, 3, 1'b1, 1, 0, 1, 1'b0);
        add_row(8192, 0, 0, 0, -3, 5, -1, 1'b1, 0, 2, 0, 1'b0);
        add_row(0, 0, 0, 16384, 7, -9, 11, 1'b1, -7, 9, 11, 1'b0);
        add_row(0, 0, 0, 16384, -32768, 100, 5, 1'b1, 32767, -100, 5, 1'b1);
        add_row(0, 16384, 0, 0, 3, -32768, 4, 1'b1, 3, 32767, -4, 1'b1);
        add_row(-32768, 0, 0, 0, 100, -200, 8191, 1'b1, 400, -800, 32764, 1'b0);
        add_row(-32768, 0, 0, 0, 8192, -8193, 0, 1'b1, 32767, -32768, 0, 1'b1);
        add_row(0, 0, 16384, 0, 1000, -2000, 3000);
        add_row(11585, 0, 0, 11585, 10000, 0, -5);
        add_row(11585, 11585, 0, 0, -32768, 32767, -32768);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_row(-32768, 32767, -32768, 32767, 32767, -32768, 32767);
        add_row(32767, -32768, 0, 0, -1, 1, -1);
        add_row(-1, -1, -1, -1, -1, -1, -1);
        add_row(21845, -21846, 21845, -21846, 21845, -21846, 21845);
        add_row(8192, 8192, 8192, 8192, 12345, -23456, 31000);
        add_row(-16384, 16384, -16384, 16384, -1, 0, 1);
        n_directed = stim_rows.size();
        for (int i = 0; i < N_RANDOM; i++) begin
            row.req = random_req();
            row.known = 1'b0;
            stim_rows.push_back(row);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        burst_left = $urandom_range(1, 48);
        for (int i = 0; i < stim_rows.size(); i++) begin
            row = stim_rows[i];
            // long output hold while input keeps offering, fills the pipeline
            if (i == n_directed)
                hold_req = 1'b1;
            @(negedge i_clk);
            i_s_axis_tdata <= {row.req.vz, row.req.vy, row.req.vx,
                               row.req.qz, row.req.qy, row.req.qx, row.req.qw};
            i_s_axis_tvalid <= 1'b1;
            @(posedge i_clk);
            while (!o_s_axis_tready)
                @(posedge i_clk);
            rot_expected.push_back(row.known ? row.res : rotate_vector(row.req));
            words_sent++;
            burst_left--;
            if (burst_left <= 0 && !(i >= n_directed && i < n_directed + N_PRESSURE)) begin
                burst_left = $urandom_range(1, 48);
                gap = $urandom_range(1, 15);
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        while (rot_expected.size() != 0)
            @(posedge i_clk);
        repeat (4 * qrv_pkg::N_STAGES) @(posedge i_clk);

        $display("sent %0d words (%0d directed, %0d random), checked %0d results, %0d saturated",
                 words_sent, n_directed, words_sent - n_directed, results_seen, sat_seen);
        $display("mismatches: %0d, results still outstanding: %0d",
                 mismatches, rot_expected.size());
        if (mismatches == 0 && rot_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
